>>> hdl/hsvpwm_pkg.sv
// Shared types, constants and helpers for the HSV to RGBW PWM compare unit.
// No dependencies; imported by every module of the block.
package hsvpwm_pkg;

   localparam int CHAN_W     = 8;
   localparam int CMP_W      = 16;
   localparam int MCAND_W    = 16;
   localparam int MPLIER_W   = 8;
   localparam int PROD_W     = MCAND_W + MPLIER_W;
   localparam int STEP_CNT_W = $clog2(PROD_W);
   localparam int NUM_CHAN   = 4;
   localparam int CHAN_IDX_W = $clog2(NUM_CHAN);
   localparam int SEXT_W     = 3;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CHAN_W-1:0] FULL_SCALE   = 8'd255;
   localparam logic [CHAN_W-1:0] HUE_SEXTANTS = 8'd6;
   localparam logic [CHAN_W-1:0] LEVEL_STEP   = 8'd10;
   localparam logic [CHAN_W-1:0] MAX_DUTY     = FULL_SCALE / LEVEL_STEP;

   localparam logic [CHAN_W-1:0] VALUE_LEVEL_RST = 8'd255;
   localparam logic [CHAN_W-1:0] WHITE_LEVEL_RST = 8'd0;
   localparam logic [CMP_W-1:0]  PWM_PERIOD_RST  = 16'd24000;
   localparam logic [CHAN_W-1:0] RED_RST         = 8'd255;
   localparam logic [CHAN_W-1:0] GREEN_RST       = 8'd0;
   localparam logic [CHAN_W-1:0] BLUE_RST        = 8'd0;
   localparam logic [CHAN_W-1:0] DUTY_RST        = 8'd10;

   // level / 10 == (level * 205) >> 11 for every 8-bit level
   localparam logic [15:0] DIV10_RECIP = 16'd205;
   localparam int          DIV10_SHIFT = 11;

   localparam logic [CSR_IDX_W-1:0] CSR_VALUE_LEVEL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WHITE_LEVEL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PWM_PERIOD  = 2'd2;

   typedef enum logic [1:0] {
      CMD_SET_COLOR = 2'd0,
      CMD_SET_LEVEL = 2'd1,
      CMD_ON        = 2'd2,
      CMD_OFF       = 2'd3
   } cmd_type;

   typedef struct packed {
      logic                start;
      logic [MCAND_W-1:0]  mcand;
      logic [MPLIER_W-1:0] mplier;
   } md_req_type;

   typedef struct packed {
      logic              done;
      logic [CMP_W-1:0]  quo;
      logic [CHAN_W-1:0] rem;
   } md_rsp_type;

   typedef struct packed {
      logic [CHAN_W-1:0] value_level;
      logic [CHAN_W-1:0] white_level;
      logic [CMP_W-1:0]  pwm_period;
   } cfg_type;

   function automatic logic [CHAN_W-1:0] div_by_ten(input logic [CHAN_W-1:0] lvl);
      logic [15:0] prod;
      prod = 16'(lvl) * DIV10_RECIP;
      return CHAN_W'(prod >> DIV10_SHIFT);
   endfunction

endpackage

>>> hdl/hsv_to_rgbw_pwm_compare_unit.sv
// Top level of the HSV to RGBW PWM compare unit: control registers,
// command sequencer and serial multiply/divide unit.
// Depends on hsvpwm_pkg, hsvpwm_muldiv, hsvpwm_ctrl.
//
//   channel   ports                          transfer when
//   --------  -----------------------------  ------------------------
//   request   req_valid/req_ready + fields   req_valid & req_ready
//   result    rsp_valid/rsp_ready + fields   rsp_valid & rsp_ready
//   control   csr_write_enable/index/data    csr_write_enable
//
// Each multiply/divide-by-255 step runs through the shared serial unit:
// a multiply pass, then a divide pass, then a registered handoff of the result.
// on, set_level and zero-saturation set_color take 8 steps; set_color with
// nonzero saturation takes 14 steps; off takes none. req_ready returns in
// the same cycle that rsp_valid rises with the result.
// One request in flight; the next is taken while a result waits for rsp_ready.
// Synchronous reset restores registers and stored color/intensity.
module hsv_to_rgbw_pwm_compare_unit
   import hsvpwm_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_command,
   input  logic [CHAN_W-1:0]    req_hue,
   input  logic [CHAN_W-1:0]    req_saturation,
   input  logic [CHAN_W-1:0]    req_level,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [CMP_W-1:0]     rsp_red_compare,
   output logic [CMP_W-1:0]     rsp_green_compare,
   output logic [CMP_W-1:0]     rsp_blue_compare,
   output logic [CMP_W-1:0]     rsp_white_compare,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CMP_W-1:0]     csr_write_data
);

   logic [CHAN_W-1:0] value_level_ff;
   logic [CHAN_W-1:0] white_level_ff;
   logic [CMP_W-1:0]  pwm_period_ff;
   cfg_type           cfg;
   md_req_type        md_req;
   md_rsp_type        md_rsp;
   logic [NUM_CHAN-1:0][CMP_W-1:0] rsp_compare;

   always_ff @(posedge clock) begin
      if (reset) begin
         value_level_ff <= VALUE_LEVEL_RST;
         white_level_ff <= WHITE_LEVEL_RST;
         pwm_period_ff  <= PWM_PERIOD_RST;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_VALUE_LEVEL) begin
            value_level_ff <= csr_write_data[CHAN_W-1:0];
         end
         if (csr_index == CSR_WHITE_LEVEL) begin
            white_level_ff <= csr_write_data[CHAN_W-1:0];
         end
         if (csr_index == CSR_PWM_PERIOD) begin
            pwm_period_ff <= csr_write_data;
         end
      end
   end

   assign cfg.value_level = value_level_ff;
   assign cfg.white_level = white_level_ff;
   assign cfg.pwm_period  = pwm_period_ff;

   hsvpwm_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .md_rsp (md_rsp)
   );

   hsvpwm_ctrl u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_level      (req_level),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_compare    (rsp_compare),
      .md_req         (md_req),
      .md_rsp         (md_rsp)
   );

   assign rsp_red_compare   = rsp_compare[0];
   assign rsp_green_compare = rsp_compare[1];
   assign rsp_blue_compare  = rsp_compare[2];
   assign rsp_white_compare = rsp_compare[3];

endmodule

>>> hdl/hsvpwm_muldiv.sv
// Serial multiply-then-divide-by-255 unit: one multiplier bit, then one
// quotient bit per cycle. Depends on hsvpwm_pkg.
module hsvpwm_muldiv
   import hsvpwm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  md_req_type md_req,
   output md_rsp_type md_rsp
);

   typedef enum logic [1:0] {
      MD_IDLE,
      MD_MUL,
      MD_DIV
   } md_state_type;

   md_state_type          state_ff, state_in;
   logic [STEP_CNT_W-1:0] cnt_ff, cnt_in;
   logic [MCAND_W-1:0]    mcand_ff, mcand_in;
   logic [MPLIER_W-1:0]   mplier_ff, mplier_in;
   logic [PROD_W-1:0]     work_ff, work_in;
   logic [CHAN_W-1:0]     rem_ff, rem_in;
   logic                  done_ff, done_in;
   logic [CHAN_W:0]       rem_trial;
   logic                  rem_ge;

   assign rem_trial = {rem_ff, work_ff[PROD_W-1]};
   assign rem_ge    = rem_trial >= {1'b0, FULL_SCALE};

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      work_in   = work_ff;
      rem_in    = rem_ff;
      done_in   = 1'b0;
      unique case (state_ff)
         MD_IDLE: begin
            if (md_req.start) begin
               mcand_in  = md_req.mcand;
               mplier_in = md_req.mplier;
               work_in   = '0;
               cnt_in    = STEP_CNT_W'(MPLIER_W - 1);
               state_in  = MD_MUL;
            end
         end
         MD_MUL: begin
            work_in   = (work_ff << 1) +
                        (mplier_ff[MPLIER_W-1] ? PROD_W'(mcand_ff) : '0);
            mplier_in = mplier_ff << 1;
            cnt_in    = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               rem_in   = '0;
               cnt_in   = STEP_CNT_W'(PROD_W - 1);
               state_in = MD_DIV;
            end
         end
         MD_DIV: begin
            rem_in  = rem_ge ? CHAN_W'(rem_trial - {1'b0, FULL_SCALE})
                             : CHAN_W'(rem_trial);
            work_in = {work_ff[PROD_W-2:0], rem_ge};
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               done_in  = 1'b1;
               state_in = MD_IDLE;
            end
         end
         default: state_in = MD_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MD_IDLE;
         cnt_ff   <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         done_ff  <= done_in;
      end
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      work_ff   <= work_in;
      rem_ff    <= rem_in;
   end

   assign md_rsp.done = done_ff;
   assign md_rsp.quo  = work_ff[CMP_W-1:0];
   assign md_rsp.rem  = rem_ff;

   a_done_after_div: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(state_ff == MD_DIV))
      else $error("done without a divide pass");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == MD_DIV) |-> (rem_ff != FULL_SCALE))
      else $error("partial remainder reached divisor");

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      md_req.start |-> (state_ff == MD_IDLE))
      else $error("start while busy");

endmodule

>>> hdl/hsvpwm_ctrl.sv
// Command sequencer: HSV conversion and compare scaling through the shared
// serial unit, level update by div_by_ten; holds the result register.
// Depends on hsvpwm_pkg.
module hsvpwm_ctrl
   import hsvpwm_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  cfg_type                     cfg,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_command,
   input  logic [CHAN_W-1:0]           req_hue,
   input  logic [CHAN_W-1:0]           req_saturation,
   input  logic [CHAN_W-1:0]           req_level,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [NUM_CHAN-1:0][CMP_W-1:0] rsp_compare,
   output md_req_type                  md_req,
   input  md_rsp_type                  md_rsp
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEXT,
      ST_P,
      ST_X,
      ST_Q,
      ST_Y,
      ST_T,
      ST_SCALE_A,
      ST_SCALE_C,
      ST_OUT
   } ctrl_state_type;

   ctrl_state_type                 state_ff, state_in;
   logic                           pend_ff, pend_in;
   logic [CHAN_W-1:0]              hue_ff, hue_in;
   logic [CHAN_W-1:0]              sat_ff, sat_in;
   logic [SEXT_W-1:0]              sext_ff, sext_in;
   logic [CHAN_W-1:0]              frac_ff, frac_in;
   logic [CHAN_W-1:0]              p_ff, p_in;
   logic [CHAN_W-1:0]              q_ff, q_in;
   logic [CHAN_W-1:0]              tmp_ff, tmp_in;
   logic [CHAN_W-1:0]              red_ff, red_in;
   logic [CHAN_W-1:0]              green_ff, green_in;
   logic [CHAN_W-1:0]              blue_ff, blue_in;
   logic [CHAN_W-1:0]              duty_ff, duty_in;
   logic [CHAN_IDX_W-1:0]          ch_ff, ch_in;
   logic [CMP_W-1:0]               scaled_ff, scaled_in;
   logic [NUM_CHAN-1:0][CMP_W-1:0] cmp_ff, cmp_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [NUM_CHAN-1:0][CMP_W-1:0] rsp_cmp_ff, rsp_cmp_in;

   logic              op_state;
   logic              op_done;
   logic [CHAN_W-1:0] chan_sel;
   logic [CHAN_W-1:0] t_val;

   assign op_state = (state_ff != ST_IDLE) && (state_ff != ST_OUT);
   assign op_done  = pend_ff && md_rsp.done;
   assign t_val    = md_rsp.quo[CHAN_W-1:0];

   always_comb begin
      unique case (ch_ff)
         2'd0:    chan_sel = red_ff;
         2'd1:    chan_sel = green_ff;
         2'd2:    chan_sel = blue_ff;
         default: chan_sel = cfg.white_level;
      endcase
   end

   always_comb begin
      md_req.start  = op_state && !pend_ff;
      md_req.mcand  = '0;
      md_req.mplier = '0;
      unique case (state_ff)
         ST_SEXT: begin
            md_req.mcand  = MCAND_W'(hue_ff);
            md_req.mplier = HUE_SEXTANTS;
         end
         ST_P: begin
            md_req.mcand  = MCAND_W'(cfg.value_level);
            md_req.mplier = FULL_SCALE - sat_ff;
         end
         ST_X: begin
            md_req.mcand  = MCAND_W'(sat_ff);
            md_req.mplier = frac_ff;
         end
         ST_Y: begin
            md_req.mcand  = MCAND_W'(sat_ff);
            md_req.mplier = FULL_SCALE - frac_ff;
         end
         ST_Q, ST_T: begin
            md_req.mcand  = MCAND_W'(cfg.value_level);
            md_req.mplier = FULL_SCALE - tmp_ff;
         end
         ST_SCALE_A: begin
            md_req.mcand  = cfg.pwm_period;
            md_req.mplier = chan_sel;
         end
         ST_SCALE_C: begin
            md_req.mcand  = scaled_ff;
            md_req.mplier = duty_ff;
         end
         default: begin
            md_req.mcand  = '0;
            md_req.mplier = '0;
         end
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      pend_in      = pend_ff;
      hue_in       = hue_ff;
      sat_in       = sat_ff;
      sext_in      = sext_ff;
      frac_in      = frac_ff;
      p_in         = p_ff;
      q_in         = q_ff;
      tmp_in       = tmp_ff;
      red_in       = red_ff;
      green_in     = green_ff;
      blue_in      = blue_ff;
      duty_in      = duty_ff;
      ch_in        = ch_ff;
      scaled_in    = scaled_ff;
      cmp_in       = cmp_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_cmp_in   = rsp_cmp_ff;

      if (md_req.start) begin
         pend_in = 1'b1;
      end else if (op_done) begin
         pend_in = 1'b0;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               hue_in = req_hue;
               sat_in = req_saturation;
               ch_in  = '0;
               unique case (cmd_type'(req_command))
                  CMD_OFF: begin
                     cmp_in   = '0;
                     state_in = ST_OUT;
                  end
                  CMD_SET_LEVEL: begin
                     duty_in  = div_by_ten(req_level);
                     state_in = ST_SCALE_A;
                  end
                  CMD_ON: begin
                     state_in = ST_SCALE_A;
                  end
                  default: begin
                     if (req_saturation == '0) begin
                        red_in   = cfg.value_level;
                        green_in = cfg.value_level;
                        blue_in  = cfg.value_level;
                        state_in = ST_SCALE_A;
                     end else begin
                        state_in = ST_SEXT;
                     end
                  end
               endcase
            end
         end
         ST_SEXT: begin
            if (op_done) begin
               sext_in  = md_rsp.quo[SEXT_W-1:0];
               frac_in  = md_rsp.rem;
               state_in = ST_P;
            end
         end
         ST_P: begin
            if (op_done) begin
               p_in     = md_rsp.quo[CHAN_W-1:0];
               state_in = ST_X;
            end
         end
         ST_X: begin
            if (op_done) begin
               tmp_in   = md_rsp.quo[CHAN_W-1:0];
               state_in = ST_Q;
            end
         end
         ST_Q: begin
            if (op_done) begin
               q_in     = md_rsp.quo[CHAN_W-1:0];
               state_in = ST_Y;
            end
         end
         ST_Y: begin
            if (op_done) begin
               tmp_in   = md_rsp.quo[CHAN_W-1:0];
               state_in = ST_T;
            end
         end
         ST_T: begin
            if (op_done) begin
               // hue 255 lands in sextant 6, handled like sextant 5
               unique case (sext_ff)
                  3'd0: begin
                     red_in = cfg.value_level; green_in = t_val; blue_in = p_ff;
                  end
                  3'd1: begin
                     red_in = q_ff; green_in = cfg.value_level; blue_in = p_ff;
                  end
                  3'd2: begin
                     red_in = p_ff; green_in = cfg.value_level; blue_in = t_val;
                  end
                  3'd3: begin
                     red_in = p_ff; green_in = q_ff; blue_in = cfg.value_level;
                  end
                  3'd4: begin
                     red_in = t_val; green_in = p_ff; blue_in = cfg.value_level;
                  end
                  default: begin
                     red_in = cfg.value_level; green_in = p_ff; blue_in = q_ff;
                  end
               endcase
               state_in = ST_SCALE_A;
            end
         end
         ST_SCALE_A: begin
            if (op_done) begin
               scaled_in = md_rsp.quo;
               state_in  = ST_SCALE_C;
            end
         end
         ST_SCALE_C: begin
            if (op_done) begin
               cmp_in[ch_ff] = md_rsp.quo;
               ch_in         = ch_ff + 1'b1;
               state_in      = (ch_ff == CHAN_IDX_W'(NUM_CHAN - 1)) ? ST_OUT : ST_SCALE_A;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_cmp_in   = cmp_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pend_ff      <= 1'b0;
         red_ff       <= RED_RST;
         green_ff     <= GREEN_RST;
         blue_ff      <= BLUE_RST;
         duty_ff      <= DUTY_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pend_ff      <= pend_in;
         red_ff       <= red_in;
         green_ff     <= green_in;
         blue_ff      <= blue_in;
         duty_ff      <= duty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      hue_ff     <= hue_in;
      sat_ff     <= sat_in;
      sext_ff    <= sext_in;
      frac_ff    <= frac_in;
      p_ff       <= p_in;
      q_ff       <= q_in;
      tmp_ff     <= tmp_in;
      ch_ff      <= ch_in;
      scaled_ff  <= scaled_in;
      cmp_ff     <= cmp_in;
      rsp_cmp_ff <= rsp_cmp_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_compare = rsp_cmp_ff;

   a_done_only_pending: assert property (@(posedge clock) disable iff (reset)
      md_rsp.done |-> pend_ff)
      else $error("serial unit result with no request pending");

   a_duty_range: assert property (@(posedge clock) disable iff (reset)
      duty_ff <= MAX_DUTY)
      else $error("duty intensity out of range");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("result raised outside output state");

endmodule

>>> sim/testbench.sv
// Self-checking testbench for hsv_to_rgbw_pwm_compare_unit: directed and random
// color/level/on/off commands across several register settings, checked by a
// scoreboard class that predicts the four PWM compares. Depends on hsvpwm_pkg.
module testbench;
   import hsvpwm_pkg::*;

   localparam int CYCLE_LIMIT = 6000000;
   localparam int PHASES      = 6;
   localparam int PHASE_ITEMS = 325;

   localparam int unsigned SEND_MIX [PHASES] = '{30, 0, 50, 20, 40, 0};
   localparam int unsigned TAKE_MIX [PHASES] = '{30, 40, 0, 20, 50, 0};

   typedef struct packed {
      logic [CMP_W-1:0] red;
      logic [CMP_W-1:0] green;
      logic [CMP_W-1:0] blue;
      logic [CMP_W-1:0] white;
   } rgbw_compares_type;

   class rgbw_scoreboard_type;
      logic [CHAN_W-1:0] value_level;
      logic [CHAN_W-1:0] white_level;
      logic [CMP_W-1:0]  pwm_period;
      logic [CHAN_W-1:0] red_level;
      logic [CHAN_W-1:0] green_level;
      logic [CHAN_W-1:0] blue_level;
      logic [CHAN_W-1:0] duty;
      rgbw_compares_type compares_q[$];
      int unsigned       mismatches;

      function new();
         value_level = VALUE_LEVEL_RST;
         white_level = WHITE_LEVEL_RST;
         pwm_period  = PWM_PERIOD_RST;
         red_level   = RED_RST;
         green_level = GREEN_RST;
         blue_level  = BLUE_RST;
         duty        = DUTY_RST;
         mismatches  = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CMP_W-1:0] data);
         case (idx)
            CSR_VALUE_LEVEL: value_level = data[CHAN_W-1:0];
            CSR_WHITE_LEVEL: white_level = data[CHAN_W-1:0];
            CSR_PWM_PERIOD:  pwm_period  = data;
            default: ;
         endcase
      endfunction

      function logic [CMP_W-1:0] scale_to_period(logic [CHAN_W-1:0] chan);
         int unsigned a;
         a = (32'(pwm_period) * 32'(chan)) / 32'(FULL_SCALE);
         return CMP_W'((a * 32'(duty)) / 32'(FULL_SCALE));
      endfunction

      function void hsv_to_levels(logic [CHAN_W-1:0] h, logic [CHAN_W-1:0] s);
         int unsigned v, sv, fs, scaled, sext, frac, p, q, t;
         v  = 32'(value_level);
         sv = 32'(s);
         fs = 32'(FULL_SCALE);
         if (s == 0) begin
            red_level   = CHAN_W'(v);
            green_level = CHAN_W'(v);
            blue_level  = CHAN_W'(v);
            return;
         end
         scaled = 32'(h) * 32'(HUE_SEXTANTS);
         sext   = scaled / fs;
         frac   = scaled % fs;
         p = (v * (fs - sv)) / fs;
         q = (v * (fs - (sv * frac) / fs)) / fs;
         t = (v * (fs - (sv * (fs - frac)) / fs)) / fs;
         case (sext)
            0: begin red_level = CHAN_W'(v); green_level = CHAN_W'(t); blue_level = CHAN_W'(p); end
            1: begin red_level = CHAN_W'(q); green_level = CHAN_W'(v); blue_level = CHAN_W'(p); end
            2: begin red_level = CHAN_W'(p); green_level = CHAN_W'(v); blue_level = CHAN_W'(t); end
            3: begin red_level = CHAN_W'(p); green_level = CHAN_W'(q); blue_level = CHAN_W'(v); end
            4: begin red_level = CHAN_W'(t); green_level = CHAN_W'(p); blue_level = CHAN_W'(v); end
            default: begin
               red_level = CHAN_W'(v); green_level = CHAN_W'(p); blue_level = CHAN_W'(q);
            end
         endcase
      endfunction

      function void note_request(cmd_type cmd, logic [CHAN_W-1:0] h, logic [CHAN_W-1:0] s,
                                 logic [CHAN_W-1:0] lvl);
         rgbw_compares_type c;
         if (cmd == CMD_OFF) begin
            c = '0;
         end else begin
            if (cmd == CMD_SET_COLOR) begin
               hsv_to_levels(h, s);
            end else if (cmd == CMD_SET_LEVEL) begin
               duty = lvl / LEVEL_STEP;
            end
            c.red   = scale_to_period(red_level);
            c.green = scale_to_period(green_level);
            c.blue  = scale_to_period(blue_level);
            c.white = scale_to_period(white_level);
         end
         compares_q.push_back(c);
      endfunction

      function void check_result(rgbw_compares_type got);
         rgbw_compares_type want;
         if (compares_q.size() == 0) begin
            $error("unexpected result transfer: %0d %0d %0d %0d",
                   got.red, got.green, got.blue, got.white);
            mismatches++;
            return;
         end
         want = compares_q.pop_front();
         if (got.red !== want.red) begin
            $error("red_compare expected %0d got %0d", want.red, got.red);
            mismatches++;
         end
         if (got.green !== want.green) begin
            $error("green_compare expected %0d got %0d", want.green, got.green);
            mismatches++;
         end
         if (got.blue !== want.blue) begin
            $error("blue_compare expected %0d got %0d", want.blue, got.blue);
            mismatches++;
         end
         if (got.white !== want.white) begin
            $error("white_compare expected %0d got %0d", want.white, got.white);
            mismatches++;
         end
      endfunction

      function int pending();
         return compares_q.size();
      endfunction
   endclass

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_ready;
   logic [1:0]           req_command      = '0;
   logic [CHAN_W-1:0]    req_hue          = '0;
   logic [CHAN_W-1:0]    req_saturation   = '0;
   logic [CHAN_W-1:0]    req_level        = '0;
   logic                 rsp_valid;
   logic                 rsp_ready        = 1'b0;
   logic [CMP_W-1:0]     rsp_red_compare;
   logic [CMP_W-1:0]     rsp_green_compare;
   logic [CMP_W-1:0]     rsp_blue_compare;
   logic [CMP_W-1:0]     rsp_white_compare;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index        = '0;
   logic [CMP_W-1:0]     csr_write_data   = '0;

   rgbw_scoreboard_type sb = new();

   int unsigned cycles       = 0;
   int unsigned send_idle    = 0;
   int unsigned take_idle    = 0;
   int unsigned ready_hold   = 0;
   bit          req_up       = 1'b0;

   logic [CHAN_W-1:0] hue_edges [11] = '{8'd0, 8'd42, 8'd43, 8'd85, 8'd127, 8'd128,
                                         8'd170, 8'd212, 8'd213, 8'd254, 8'd255};

   hsv_to_rgbw_pwm_compare_unit dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_command       (req_command),
      .req_hue           (req_hue),
      .req_saturation    (req_saturation),
      .req_level         (req_level),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_red_compare   (rsp_red_compare),
      .rsp_green_compare (rsp_green_compare),
      .rsp_blue_compare  (rsp_blue_compare),
      .rsp_white_compare (rsp_white_compare),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) begin
         sb.note_request(cmd_type'(req_command), req_hue, req_saturation, req_level);
      end
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_result({rsp_red_compare, rsp_green_compare, rsp_blue_compare,
                          rsp_white_compare});
      end
   end

   // result-side backpressure in random bursts with rsp_ready held low
   always @(posedge clock) begin
      if (ready_hold != 0) begin
         ready_hold <= ready_hold - 1;
      end else if ($urandom_range(99) < take_idle) begin
         rsp_ready  <= 1'b0;
         ready_hold <= $urandom_range(0, 5);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_cmd(input cmd_type cmd, input logic [CHAN_W-1:0] h,
                           input logic [CHAN_W-1:0] s, input logic [CHAN_W-1:0] lvl);
      req_valid      <= 1'b1;
      req_command    <= cmd;
      req_hue        <= h;
      req_saturation <= s;
      req_level      <= lvl;
      req_up = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         req_up = 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      if (req_up) begin
         req_valid <= 1'b0;
         req_up = 1'b0;
      end
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_regs(input logic [CHAN_W-1:0] value_lvl,
                             input logic [CHAN_W-1:0] white_lvl,
                             input logic [CMP_W-1:0] period);
      logic [CMP_W-1:0] data [3];
      data[CSR_VALUE_LEVEL] = {CHAN_W'($urandom), value_lvl};
      data[CSR_WHITE_LEVEL] = {CHAN_W'($urandom), white_lvl};
      data[CSR_PWM_PERIOD]  = period;
      for (int i = 0; i < 3; i++) begin
         csr_write_enable <= 1'b1;
         csr_index        <= CSR_IDX_W'(i);
         csr_write_data   <= data[i];
         sb.write_reg(CSR_IDX_W'(i), data[i]);
         @(posedge clock);
      end
      csr_write_enable <= 1'b0;
   endtask

   task automatic send_random();
      cmd_type           cmd;
      logic [CHAN_W-1:0] h, s;
      int unsigned       pick;
      pick = $urandom_range(99);
      if (pick < 50)      cmd = CMD_SET_COLOR;
      else if (pick < 70) cmd = CMD_SET_LEVEL;
      else if (pick < 85) cmd = CMD_ON;
      else                cmd = CMD_OFF;
      h = ($urandom_range(9) == 0) ? hue_edges[$urandom_range(10)] : CHAN_W'($urandom);
      pick = $urandom_range(99);
      if (pick < 10)      s = '0;
      else if (pick < 15) s = FULL_SCALE;
      else                s = CHAN_W'($urandom);
      send_cmd(cmd, h, s, CHAN_W'($urandom));
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset color and intensity, then level and hue corners
      send_idle = 20;
      take_idle = 20;
      send_cmd(CMD_ON, 8'd0, 8'd0, 8'd0);
      send_cmd(CMD_OFF, 8'hFF, 8'hFF, 8'hFF);
      send_cmd(CMD_SET_LEVEL, 8'd0, 8'd0, 8'd0);
      send_cmd(CMD_SET_LEVEL, 8'd0, 8'd0, 8'd9);
      send_cmd(CMD_SET_LEVEL, 8'd0, 8'd0, 8'd10);
      send_cmd(CMD_SET_LEVEL, 8'd0, 8'd0, 8'd255);
      send_cmd(CMD_SET_COLOR, 8'd0, 8'd255, 8'd0);
      send_cmd(CMD_SET_COLOR, 8'd42, 8'd255, 8'd0);
      send_cmd(CMD_SET_COLOR, 8'd43, 8'd255, 8'd0);
      send_cmd(CMD_SET_COLOR, 8'd85, 8'd200, 8'd0);
      send_cmd(CMD_SET_COLOR, 8'd128, 8'd255, 8'd0);
      send_cmd(CMD_SET_COLOR, 8'd170, 8'd1, 8'd0);
      send_cmd(CMD_SET_COLOR, 8'd213, 8'd255, 8'd0);
      send_cmd(CMD_SET_COLOR, 8'd255, 8'd255, 8'd0);
      send_cmd(CMD_SET_COLOR, 8'd255, 8'd0, 8'd0);
      send_cmd(CMD_SET_COLOR, 8'd100, 8'd0, 8'd77);
      send_cmd(CMD_ON, 8'd0, 8'd0, 8'd0);
      send_cmd(CMD_OFF, 8'd0, 8'd0, 8'd0);
      wait_idle();

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            1: write_regs(8'd0, 8'd255, 16'hFFFF);
            2: write_regs(8'd255, 8'd0, 16'd1);
            3: write_regs(CHAN_W'($urandom), CHAN_W'($urandom), 16'd0);
            4: write_regs(CHAN_W'($urandom), CHAN_W'($urandom), 16'hFFFF);
            5: write_regs(CHAN_W'($urandom), CHAN_W'($urandom), CMP_W'($urandom));
            default: ;
         endcase
         send_idle = SEND_MIX[ph];
         take_idle = TAKE_MIX[ph];
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            send_random();
            if (ph != PHASES - 1 && $urandom_range(99) == 0) wait_idle();
         end
         wait_idle();
      end

      repeat (600) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
